[sv/seven_segment_number_display_frames_unit_macros.svh]
// Assertion macros shared by the display frame unit.
`ifndef SEVEN_SEGMENT_NUMBER_DISPLAY_FRAMES_UNIT_MACROS_SVH
`define SEVEN_SEGMENT_NUMBER_DISPLAY_FRAMES_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define SSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/ssd_pkg.sv]
// Shared types, constants and the segment table of the display frame unit.
package ssd_pkg;

  localparam int unsigned DIGIT_COUNT = 4;
  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned BRIGHT_W    = 3;

  typedef logic [7:0]                  byte_t;
  typedef logic [VALUE_W-1:0]          mag_t;
  typedef logic [BRIGHT_W-1:0]         bright_t;
  typedef logic [DIGIT_COUNT-1:0][7:0] seg_vec_t;

  localparam bright_t BRIGHT_RESET = bright_t'(7);

  // Bus commands and segment patterns.
  localparam byte_t CMD_DATA  = 8'h40;
  localparam byte_t CMD_ADDR  = 8'hC0;
  localparam byte_t CMD_CTRL  = 8'h80;
  localparam byte_t CTRL_ON   = 8'h08;
  localparam byte_t SEG_MINUS = 8'h40;
  localparam byte_t SEG_BLANK = 8'h00;

  // x / 10 == (x * 52429) >> 19 holds exactly for every 16-bit x.
  localparam mag_t        RECIP_10    = 16'd52429;
  localparam int unsigned RECIP_SHIFT = 19;

  // Digit loop counter in the front part.
  localparam int unsigned SEG_SEL_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  typedef logic [SEG_SEL_W-1:0] step_t;
  localparam step_t STEP_LAST = step_t'(DIGIT_COUNT - 1);

  // Byte position within one request's frames.
  localparam int unsigned FRAME_BYTES = DIGIT_COUNT + 3;
  localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);
  typedef logic [IDX_W-1:0] idx_t;
  localparam idx_t IDX_DATA     = idx_t'(0);
  localparam idx_t IDX_ADDR     = idx_t'(1);
  localparam idx_t IDX_SEG0     = idx_t'(2);
  localparam idx_t IDX_SEG_LAST = idx_t'(FRAME_BYTES - 2);
  localparam idx_t IDX_CTRL     = idx_t'(FRAME_BYTES - 1);

  // Queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  typedef logic [QPTR_W-1:0] qptr_t;
  typedef logic [QCNT_W-1:0] qcnt_t;
  localparam qptr_t Q_PTR_LAST = qptr_t'(QUEUE_DEPTH - 1);
  localparam qcnt_t Q_CNT_FULL = qcnt_t'(QUEUE_DEPTH);

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Segment byte for one decimal digit, bit 0 = segment a.
  function automatic byte_t seg_of(input logic [3:0] digit);
    byte_t seg;
    unique case (digit)
      4'd0:    seg = 8'h3f;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5b;
      4'd3:    seg = 8'h4f;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6d;
      4'd6:    seg = 8'h7d;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7f;
      4'd9:    seg = 8'h6f;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

endpackage

[sv/ssd_ifs.sv]
// Handshake channel interfaces of the display frame unit.
interface ssd_in_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic signed [ssd_pkg::VALUE_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface ssd_out_if;
  logic               valid;
  logic               ready;
  ssd_pkg::byte_t     bus_byte;
  logic               frame_start;
  logic               frame_stop;
  logic               last;

  modport source (output valid, output bus_byte, output frame_start, output frame_stop,
                  output last, input ready);
  modport sink   (input valid, input bus_byte, input frame_start, input frame_stop,
                  input last, output ready);
endinterface

interface ssd_cfg_if;
  logic             valid;
  logic             ready;
  ssd_pkg::bright_t brightness;

  modport source (output valid, output brightness, input ready);
  modport sink   (input valid, input brightness, output ready);
endinterface

[sv/ssd_front.sv]
// Front part: accepts requests and renders segment bytes, one digit a cycle, the last when the queue has room.
module ssd_front (
  input  logic              clk,
  input  logic              rst_n,
  ssd_in_if.sink            in_ch,
  input  ssd_pkg::q_stat_t  q_stat,
  output logic              push,
  output ssd_pkg::seg_vec_t push_data
);

  logic              busy_r, busy_nxt;
  ssd_pkg::step_t    step_r, step_nxt;
  ssd_pkg::mag_t     mag_r, mag_nxt;
  logic              neg_r, neg_nxt;
  logic              clr_r, clr_nxt;
  ssd_pkg::seg_vec_t segs_r, segs_nxt;

  logic [31:0]       prod;
  ssd_pkg::mag_t     quo;
  ssd_pkg::mag_t     rem_full;
  ssd_pkg::mag_t     raw;
  logic [3:0]        digit;
  logic              is_digit;
  ssd_pkg::byte_t    seg;
  ssd_pkg::step_t    pos;
  logic              last_step;
  logic              accept;

  always_comb begin
    raw      = in_ch.value;
    prod     = 32'(mag_r) * 32'(ssd_pkg::RECIP_10);
    quo      = ssd_pkg::mag_t'(prod >> ssd_pkg::RECIP_SHIFT);
    rem_full = mag_r - ((quo << 3) + (quo << 1));
    digit    = rem_full[3:0];
    // Unless clearing, the rightmost position always shows a digit, even for zero.
    is_digit = (digit != 4'd0) || (quo != '0) || (step_r == '0);

    priority if (clr_r) begin
      seg = ssd_pkg::SEG_BLANK;
    end else if (is_digit) begin
      seg = ssd_pkg::seg_of(digit);
    end else if (neg_r) begin
      seg = ssd_pkg::SEG_MINUS;
    end else begin
      seg = ssd_pkg::SEG_BLANK;
    end

    pos       = ssd_pkg::STEP_LAST - step_r;
    last_step = busy_r && (step_r == ssd_pkg::STEP_LAST);
    push      = last_step && !q_stat.full;
    in_ch.ready = !busy_r || push;
    accept    = in_ch.valid && in_ch.ready;

    // The last step always fills the leftmost position.
    push_data    = segs_r;
    push_data[0] = seg;

    busy_nxt = busy_r;
    step_nxt = step_r;
    mag_nxt  = mag_r;
    neg_nxt  = neg_r;
    clr_nxt  = clr_r;
    segs_nxt = segs_r;

    if (busy_r && !last_step) begin
      segs_nxt[pos] = seg;
      mag_nxt       = quo;
      neg_nxt       = neg_r && is_digit;
      step_nxt      = step_r + ssd_pkg::step_t'(1);
    end
    if (push) begin
      busy_nxt = 1'b0;
    end
    if (accept) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      clr_nxt  = in_ch.func;
      neg_nxt  = !in_ch.func && raw[ssd_pkg::VALUE_W-1];
      if (in_ch.func) begin
        mag_nxt = '0;
      end else if (raw[ssd_pkg::VALUE_W-1]) begin
        mag_nxt = ~raw + ssd_pkg::mag_t'(1);
      end else begin
        mag_nxt = raw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    clr_r  <= clr_nxt;
    segs_r <= segs_nxt;
  end

endmodule

[sv/ssd_queue.sv]
// Short queue of rendered segment sets between the front and back parts.
module ssd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ssd_pkg::seg_vec_t push_data,
  input  logic              pop,
  output ssd_pkg::seg_vec_t rd_data,
  output ssd_pkg::q_stat_t  q_stat
);

  ssd_pkg::seg_vec_t ent_r [ssd_pkg::QUEUE_DEPTH];
  ssd_pkg::qptr_t    wr_ptr_r, wr_ptr_nxt;
  ssd_pkg::qptr_t    rd_ptr_r, rd_ptr_nxt;
  ssd_pkg::qcnt_t    cnt_r, cnt_nxt;

  always_comb begin
    q_stat.full  = (cnt_r == ssd_pkg::Q_CNT_FULL);
    q_stat.empty = (cnt_r == '0);
    rd_data      = ent_r[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == ssd_pkg::Q_PTR_LAST) ? '0 : wr_ptr_r + ssd_pkg::qptr_t'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == ssd_pkg::Q_PTR_LAST) ? '0 : rd_ptr_r + ssd_pkg::qptr_t'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + ssd_pkg::qcnt_t'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - ssd_pkg::qcnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[sv/ssd_back.sv]
// Back part: holds brightness and sends the frame bytes of one request, one per cycle while out_ch is ready.
module ssd_back (
  input  logic              clk,
  input  logic              rst_n,
  ssd_cfg_if.sink           cfg_ch,
  ssd_out_if.source         out_ch,
  input  ssd_pkg::seg_vec_t rd_data,
  input  ssd_pkg::q_stat_t  q_stat,
  output logic              pop
);

  ssd_pkg::bright_t brightness_r, brightness_nxt;
  ssd_pkg::idx_t    idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  ssd_pkg::byte_t   byte_r, byte_nxt;
  logic             start_r, start_nxt;
  logic             stop_r, stop_nxt;
  logic             last_r, last_nxt;

  logic                      advance;
  logic                      load;
  ssd_pkg::idx_t             seg_off;
  logic [ssd_pkg::SEG_SEL_W-1:0] seg_sel;

  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.bus_byte    = byte_r;
  assign out_ch.frame_start = start_r;
  assign out_ch.frame_stop  = stop_r;
  assign out_ch.last        = last_r;

  always_comb begin
    brightness_nxt = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.brightness : brightness_r;

    advance = !out_valid_r || out_ch.ready;
    load    = advance && !q_stat.empty;
    pop     = load && (idx_r == ssd_pkg::IDX_CTRL);

    seg_off = idx_r - ssd_pkg::IDX_SEG0;
    seg_sel = seg_off[ssd_pkg::SEG_SEL_W-1:0];

    priority if (idx_r == ssd_pkg::IDX_DATA) begin
      byte_nxt  = ssd_pkg::CMD_DATA;
      start_nxt = 1'b1;
      stop_nxt  = 1'b1;
      last_nxt  = 1'b0;
    end else if (idx_r == ssd_pkg::IDX_ADDR) begin
      byte_nxt  = ssd_pkg::CMD_ADDR;
      start_nxt = 1'b1;
      stop_nxt  = 1'b0;
      last_nxt  = 1'b0;
    end else if (idx_r == ssd_pkg::IDX_CTRL) begin
      byte_nxt  = ssd_pkg::CMD_CTRL | ssd_pkg::CTRL_ON | ssd_pkg::byte_t'(brightness_r);
      start_nxt = 1'b1;
      stop_nxt  = 1'b1;
      last_nxt  = 1'b1;
    end else begin
      byte_nxt  = rd_data[seg_sel];
      start_nxt = 1'b0;
      stop_nxt  = (idx_r == ssd_pkg::IDX_SEG_LAST);
      last_nxt  = 1'b0;
    end

    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = (idx_r == ssd_pkg::IDX_CTRL) ? ssd_pkg::IDX_DATA : idx_r + ssd_pkg::idx_t'(1);
    end

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (advance) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= ssd_pkg::BRIGHT_RESET;
      idx_r        <= ssd_pkg::IDX_DATA;
      out_valid_r  <= 1'b0;
    end else begin
      brightness_r <= brightness_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r  <= byte_nxt;
      start_r <= start_nxt;
      stop_r  <= stop_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

[sv/seven_segment_number_display_frames_unit.sv]
// Top level of the seven-segment display frame unit.
//
//   channel   direction  transaction carries
//   in_ch     sink       func (show/clear), value (signed 16 bit)
//   out_ch    source     bus_byte, frame_start, frame_stop, last
//   cfg_ch    sink       brightness (3 bit)
//
// Every request gives seven output transactions: the data command, the address
// command, the four segment bytes and the control command. The back part sends one
// byte per cycle while out_ch is ready and the queue holds an entry; that byte
// sequencer sets the rate. The front part works on one 16x16 reciprocal
// multiplier, one decimal digit a cycle with the last one held while the queue is
// full, and overlaps with the back part through a two-entry queue. When the block
// is empty the first byte passes the front part's digit steps, the queue and the
// back part's output register before it is valid. Reset sets brightness to 7
// and empties the queue. A stall on out_ch fills the queue and then holds in_ch
// ready low; the configuration port is always ready.
`include "seven_segment_number_display_frames_unit_macros.svh"

module seven_segment_number_display_frames_unit (
  input  logic      clk,
  input  logic      rst_n,
  ssd_in_if.sink    in_ch,
  ssd_out_if.source out_ch,
  ssd_cfg_if.sink   cfg_ch
);

  // Handoff between the front part and the queue.
  logic              push;
  ssd_pkg::seg_vec_t push_data;

  // Handoff between the queue and the back part.
  logic              pop;
  ssd_pkg::seg_vec_t rd_data;
  ssd_pkg::q_stat_t  q_stat;

  // The front part renders the digits of the accepted request and pushes one
  // complete segment set into the queue once the last digit is known.
  ssd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  ssd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .rd_data   (rd_data),
    .q_stat    (q_stat)
  );

  // The back part frames the queue head and retires it with the control byte.
  ssd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_ch  (cfg_ch),
    .out_ch  (out_ch),
    .rd_data (rd_data),
    .q_stat  (q_stat),
    .pop     (pop)
  );

  // The back part only retires an entry that is there.
  `SSD_ASSERT_NOW(a_pop_not_empty, pop, !q_stat.empty, "queue popped while empty")
  // The front part never overruns the queue.
  `SSD_ASSERT_NOW(a_push_not_full, push, !q_stat.full, "queue pushed while full")
  // A push without a pop leaves work for the back part.
  `SSD_ASSERT_NEXT(a_push_fills, push && !pop, !q_stat.empty, "pushed entry went missing")
  // The final byte of a request is always a frame of its own.
  `SSD_ASSERT_NOW(a_last_framed, out_ch.valid && out_ch.last, out_ch.frame_start && out_ch.frame_stop, "last byte lacks start or stop")

endmodule
